/* hdl/bf16as_pkg.sv */
// Package for the bfloat16 adder/subtractor: field widths and constants.
// No dependencies.
package bf16as_pkg;
    localparam int WordW  = 16;
    localparam int ExpW   = 8;
    localparam int SigW   = 8;
    localparam int AlW    = 11;
    localparam int ExW    = 16;

    localparam logic [7:0] HiddenBit = 8'h80;
    localparam logic [6:0] FracMask  = 7'h7F;

    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } op_t;
endpackage

/* hdl/bfloat16_adder_subtractor_unit.sv */
// Top level of the bfloat16 adder/subtractor, a four-stage pipeline.
// Depends on bf16as_pkg.
//
// Usage:
//   Input channel: in_valid/in_ready with operand_a, operand_b, req_type
//   (0 = a + b, 1 = a - b). Output channel: out_valid/out_ready with sum_value.
//   A transfer happens on a rising edge with valid and ready both high.
//   Special encodings (zero, subnormal, inf, NaN) are treated as normal numbers.
//   Output: the result is valid once the item reaches the normalize/pack register
//   and transfers on a rising edge with out_ready high.
//   Throughput: one transfer per cycle while out_ready is high; the four register stages
//   (align, add/sub, round, normalize/pack) each hold one item.
//   Stall: when out_ready is low, a stage holds its item if the stage after
//   it is full and held; bubbles are squeezed out, so in_ready stays high
//   while any stage is empty. Nothing is lost or repeated.
//   Reset: rst_n is asynchronous, active low, and clears all valid bits;
//   the block accepts input as soon as reset is released.
//   The last stage register drives the output ports directly.
//   The normalize step is a priority shift on an 8-bit value.
module bfloat16_adder_subtractor_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bf16as_pkg::WordW-1:0] operand_a,
    input  logic [bf16as_pkg::WordW-1:0] operand_b,
    input  logic                        req_type,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bf16as_pkg::WordW-1:0] sum_value
);
    import bf16as_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: align
    logic [ExpW-1:0] ea, eb, d;
    logic [SigW-1:0] ma, mb, small_sig;
    logic a_gt;
    logic [AlW-1:0] al_small;
    logic [AlW-1:0] xa1_next, xb1_next;
    logic [ExpW-1:0] ex1_next;
    logic sub1_next;

    always_comb
    begin
        ea = operand_a[14:7];
        eb = operand_b[14:7];
        ma = HiddenBit | {1'b0, operand_a[6:0]};
        mb = HiddenBit | {1'b0, operand_b[6:0]};
        a_gt = ea > eb;
        d = a_gt ? ea - eb : eb - ea;
        small_sig = a_gt ? mb : ma;
        case (d)
            8'd0:    al_small = {small_sig, 3'b000};
            8'd1:    al_small = {1'b0, small_sig, 2'b00};
            8'd2:    al_small = {2'b00, small_sig, 1'b0};
            8'd3:    al_small = {3'b000, small_sig};
            8'd4:    al_small = {4'b0, small_sig[7:1]};
            8'd5:    al_small = {5'b0, small_sig[7:2]};
            8'd6:    al_small = {6'b0, small_sig[7:3]};
            8'd7:    al_small = {7'b0, small_sig[7:4]};
            8'd8:    al_small = {8'b0, small_sig[7:5]};
            default: al_small = '0;
        endcase
        xa1_next = a_gt ? {ma, 3'b000} : al_small;
        xb1_next = a_gt ? al_small : {mb, 3'b000};
        ex1_next = a_gt ? ea : eb;
        sub1_next = req_type ^ operand_a[15] ^ operand_b[15];
    end

    logic [AlW-1:0] xa1_reg, xb1_reg;
    logic [ExpW-1:0] ex1_reg;
    logic sub1_reg, sa1_reg, sb1_reg, op1_reg;

    // stage 2: add/sub magnitude
    logic [AlW:0] sig2_next;
    logic sign2_next;
    logic a_big;

    always_comb
    begin
        a_big = xa1_reg > xb1_reg;
        if (sub1_reg)
        begin
            sig2_next = a_big ? {1'b0, xa1_reg - xb1_reg} : {1'b0, xb1_reg - xa1_reg};
            sign2_next = a_big ? sa1_reg : (sb1_reg ^ op1_reg);
        end
        else
        begin
            sig2_next = {1'b0, xa1_reg} + {1'b0, xb1_reg};
            sign2_next = sa1_reg;
        end
    end

    logic [AlW:0] sig2_reg;
    logic sign2_reg, sub2_reg;
    logic [ExpW-1:0] ex2_reg;

    // stage 3: carry fix and round
    logic [AlW-1:0] s3;
    logic [ExW-1:0] e3;
    logic [SigW:0] m3;
    logic [SigW-1:0] sig3_next;
    logic [ExW-1:0] ex3_next;
    logic zero3_next;

    always_comb
    begin
        s3 = sig2_reg[AlW-1:0];
        e3 = {8'b0, ex2_reg};
        if (!sub2_reg && sig2_reg[AlW])
        begin
            s3 = sig2_reg[AlW:1];
            e3 = e3 + 16'd1;
        end
        m3 = {1'b0, s3[10:3]};
        if (s3[2:0] > 3'd4 || (s3[2:0] == 3'd4 && s3[3]))
            m3 = m3 + 9'd1;
        sig3_next = m3[7:0];
        ex3_next = e3;
        if (m3[8])
        begin
            sig3_next = m3[8:1];
            ex3_next = e3 + 16'd1;
        end
        zero3_next = (sig2_reg == '0) || (sub2_reg && m3 == '0);
    end

    logic [SigW-1:0] sig3_reg;
    logic [ExW-1:0] ex3_reg;
    logic zero3_reg, sign3_reg;

    // stage 4: normalize and pack
    logic [2:0] lz;
    logic [SigW-1:0] sn;
    logic [ExW-1:0] en_;
    logic [WordW-1:0] res4_next;

    always_comb
    begin
        lz = 3'd7;
        for (int i = 0; i < 8; i++)
        begin
            if (sig3_reg[i])
                lz = 3'(7 - i);
        end
        sn = sig3_reg << lz;
        en_ = ex3_reg - {13'b0, lz};
        if (zero3_reg)
        begin
            sn = '0;
            en_ = '0;
        end
        if (en_[8])
            res4_next = {sign3_reg, 8'hFF, 7'h00};
        else
            res4_next = {sign3_reg, en_[7:0], sn[6:0]};
    end

    logic [WordW-1:0] res4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            xa1_reg <= xa1_next;
            xb1_reg <= xb1_next;
            ex1_reg <= ex1_next;
            sub1_reg <= sub1_next;
            sa1_reg <= operand_a[15];
            sb1_reg <= operand_b[15];
            op1_reg <= req_type;
        end
        if (en2 && v1_reg)
        begin
            sig2_reg <= sig2_next;
            sign2_reg <= sign2_next;
            sub2_reg <= sub1_reg;
            ex2_reg <= ex1_reg;
        end
        if (en3 && v2_reg)
        begin
            sig3_reg <= sig3_next;
            ex3_reg <= ex3_next;
            zero3_reg <= zero3_next;
            sign3_reg <= sign2_reg;
        end
        if (en4 && v3_reg)
            res4_reg <= res4_next;
    end

    assign out_valid = v4_reg;
    assign sum_value = res4_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_value))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> in_ready)
        else $error("input blocked with empty first stage");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && en4 |=> v4_reg)
        else $error("item lost between last stages");
endmodule

/* tb/tb_bfloat16_adder_subtractor_unit.sv */
// Testbench for bfloat16_adder_subtractor_unit: directed and random add/sub
// transfers checked against a behavioral bfloat16 predictor. Depends on bf16as_pkg.
`timescale 1ns / 100ps

module tb_bfloat16_adder_subtractor_unit;
    import bf16as_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        req_type;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] sum_value;

    logic [15:0] sum_q[$];
    int          err_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    bit          done;

    bfloat16_adder_subtractor_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum_value (sum_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] align_sig(logic [15:0] sig, logic [7:0] diff);
        if (diff <= 3)
            return sig << (3 - diff);
        if (diff <= 8)
            return sig >> (diff - 3);
        return '0;
    endfunction

    function automatic void round_rne(inout logic [15:0] sig, inout logic [15:0] ex);
        logic [2:0]  grs;
        logic [15:0] m;
        grs = sig[2:0];
        m = sig >> 3;
        if (grs > 3'd4 || (grs == 3'd4 && sig[3]))
            m = m + 16'd1;
        if (m[8])
        begin
            m = m >> 1;
            ex = ex + 16'd1;
        end
        sig = m;
    endfunction

    function automatic logic [15:0] bf16_addsub(logic [15:0] a, logic [15:0] b, op_t op);
        logic [7:0]  ea, eb;
        logic [15:0] ma, mb, xa, xb, ex, sig;
        logic        sa, sb, sign, a_big;
        int          n;
        ea = a[14:7];
        eb = b[14:7];
        ma = {8'h0, HiddenBit | {1'b0, a[6:0]}};
        mb = {8'h0, HiddenBit | {1'b0, b[6:0]}};
        sa = a[15];
        sb = b[15];
        if (ea > eb)
        begin
            xb = align_sig(mb, ea - eb);
            xa = ma << 3;
            ex = {8'h0, ea};
        end
        else
        begin
            xa = align_sig(ma, eb - ea);
            xb = mb << 3;
            ex = {8'h0, eb};
        end
        if ((op == OP_SUB) ^ sa ^ sb)
        begin
            a_big = xa > xb;
            sig = a_big ? xa - xb : xb - xa;
            sign = a_big ? sa : (sb ^ (op == OP_SUB));
            round_rne(sig, ex);
            if (sig == '0)
                ex = '0;
            else
            begin
                n = 0;
                while (!sig[7] && n < 16)
                begin
                    sig = sig << 1;
                    ex = ex - 16'd1;
                    n++;
                end
            end
        end
        else
        begin
            sig = xa + xb;
            sign = sa;
            if (sig == '0)
                ex = '0;
            else
            begin
                if (sig[11])
                begin
                    sig = sig >> 1;
                    ex = ex + 16'd1;
                end
                round_rne(sig, ex);
            end
        end
        if (ex[8])
            return {sign, 8'hFF, 7'h0};
        return {sign, ex[7:0], sig[6:0]};
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    task automatic send_op(logic [15:0] a, logic [15:0] b, op_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        req_type  <= op;
        sum_q.push_back(bf16_addsub(a, b, op));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sum_q.size() == 0)
                report_mismatch("unexpected transfer", sum_value, 16'h0);
            else
            begin
                if (sum_value !== sum_q[0])
                    report_mismatch("sum_value", sum_value, sum_q[0]);
                void'(sum_q.pop_front());
            end
        end
    end

    function automatic logic [15:0] rand_bf16();
        logic [15:0] v;
        v = 16'($urandom);
        return v;
    endfunction

    task automatic test_directed();
        send_op(16'h0000, 16'h0000, OP_ADD);
        send_op(16'h3F80, 16'h3F80, OP_SUB);
        send_op(16'hBF80, 16'h3F80, OP_ADD);
        send_op(16'hFFFF, 16'hFFFF, OP_ADD);
        send_op(16'h7FFF, 16'h7F80, OP_ADD);
        send_op(16'h0000, 16'h7F80, OP_ADD);
        send_op(16'h0080, 16'h0000, OP_SUB);
        send_op(16'h0000, 16'h0080, OP_SUB);
        send_op(16'h3F80, 16'h3E00, OP_ADD);
        send_op(16'h3F80, 16'h3D80, OP_ADD);
        send_op(16'h3F80, 16'h3B80, OP_ADD);
        send_op(16'h3F80, 16'h3B00, OP_SUB);
        send_op(16'h3F80, 16'h3A80, OP_ADD);
        send_op(16'h3FFF, 16'h3C7F, OP_ADD);
        send_op(16'h3F81, 16'h3F80, OP_SUB);
        send_op(16'h4000, 16'h3FFF, OP_SUB);
        send_op(16'h0100, 16'h00FF, OP_SUB);
        send_op(16'h7F7F, 16'h7F7F, OP_ADD);
        send_op(16'hFF7F, 16'h7F00, OP_SUB);
        send_op(16'h3FFF, 16'h3F80, OP_ADD);
        send_op(16'h8000, 16'h8000, OP_SUB);
    endtask

    task automatic test_random(int count);
        logic [15:0] a, b;
        for (int i = 0; i < count; i++)
        begin
            a = rand_bf16();
            b = rand_bf16();
            if ($urandom_range(3) != 0)
                b[14:7] = 8'(a[14:7] + $urandom_range(20) - 10);
            send_op(a, b, op_t'($urandom_range(1)));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 60;
        for (int i = 0; i < 20; i++)
            send_op(rand_bf16(), rand_bf16(), op_t'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operand_a = '0;
        operand_b = '0;
        req_type = 1'b0;
        out_ready = 1'b0;
        err_cnt = 0;
        hold_cycles = 0;
        done = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 66;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(230);
        send_idle_pct = 66;
        recv_idle_pct = 33;
        test_random(230);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(250);
        in_valid <= 1'b0;
        while (sum_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        done = 1'b1;
        if (err_cnt == 0)
            $display("[bfloat16_adder_subtractor_unit] OK");
        else
            $display("[bfloat16_adder_subtractor_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        if (!done)
        begin
            $display("timeout");
            $display("[bfloat16_adder_subtractor_unit] ERROR");
            $finish;
        end
    end
endmodule

/* filelist.f */
hdl/bf16as_pkg.sv
hdl/bfloat16_adder_subtractor_unit.sv
tb/tb_bfloat16_adder_subtractor_unit.sv
